// File: hw/rtl/mmsr_pkg.sv
// Shared constants and types of the mixer mute/solo resolver.
`timescale 1ns / 1ps
`default_nettype none

package mmsr_pkg;

  localparam int MAX_TRACKS = 64;
  localparam int ID_W       = 7;
  localparam int SLOT_W     = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

  // One entry of the track memory.
  typedef struct packed {
    logic            group;
    logic            soloed;
    logic            muted;
    logic [ID_W-1:0] parent;
    logic            present;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/mmsr_in_if.sv
// Input channel of the resolver: one write or query word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface mmsr_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [mmsr_pkg::ID_W-1:0] track_id;
  logic                     present;
  logic [mmsr_pkg::ID_W-1:0] parent_id;
  logic                     muted_flag;
  logic                     soloed_flag;
  logic                     is_group;

  modport source (output valid, mode, track_id, present, parent_id, muted_flag,
                  soloed_flag, is_group, input ready);
  modport sink   (input valid, mode, track_id, present, parent_id, muted_flag,
                  soloed_flag, is_group, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mmsr_out_if.sv
// Result channel of the resolver: one result word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface mmsr_out_if;
  logic valid;
  logic ready;
  logic audible;
  logic any_solo;
  logic known;

  modport source (output valid, audible, any_solo, known, input ready);
  modport sink   (input valid, audible, any_solo, known, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mmsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mmsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mixer_mute_solo_resolver.sv
// Top level of the mixer mute/solo resolver: track memory, walk sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a 64-entry track table in one synchronous RAM and handles one word at a
// time. For a write word the accepting cycle reads the old entry, the lookup state updates
// the entry and the counts, and the done state loads the result register. A query reads the
// ancestors on the parent chain one at a time, at most track_count of them, through the
// single read port of the track RAM. The done state waits while an earlier result has not
// been taken. Per-entry valid flops mark the table empty at reset, so no clearing pass is
// needed. A new word is accepted as soon as the sequencer is idle, even while the previous
// result still waits in the output register.
module mixer_mute_solo_resolver (
  input wire logic  clk,
  input wire logic  rst,
  mmsr_in_if.sink   req,
  mmsr_out_if.source rsp
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state;

  // Latched input word.
  logic                      cur_mode;
  logic [mmsr_pkg::ID_W-1:0] cur_id;
  logic                      cur_present;
  logic [mmsr_pkg::ID_W-1:0] cur_parent;
  logic                      cur_muted;
  logic                      cur_soloed;
  logic                      cur_group;

  // Walk state.
  logic                       own_muted;
  logic                       own_soloed;
  logic                       own_group;
  logic                       mute_anc;
  logic                       solo_anc;
  logic [mmsr_pkg::ID_W-1:0]  walk_pid;
  logic [mmsr_pkg::CNT_W-1:0] steps;

  logic [mmsr_pkg::CNT_W-1:0]    track_count;
  logic [mmsr_pkg::CNT_W-1:0]    solo_count;
  logic [mmsr_pkg::MAX_TRACKS-1:0] vld;

  logic res_aud;
  logic res_known;

  logic                       ram_we;
  logic                       ram_re;
  logic [mmsr_pkg::SLOT_W-1:0] ram_raddr;
  logic [mmsr_pkg::SLOT_W-1:0] rd_slot;
  logic [mmsr_pkg::ENTRY_W-1:0] ram_rdata;
  mmsr_pkg::entry_t            entry_rd;
  mmsr_pkg::entry_t            entry_wr;

  logic                       id_ok;
  logic                       cand_ok;
  logic [mmsr_pkg::CNT_W-1:0] cand_steps;
  logic                       walk_stop;
  logic                       mute_n;
  logic                       solo_n;
  logic                       out_free;
  logic [mmsr_pkg::CNT_W-1:0] track_count_next;
  logic [mmsr_pkg::CNT_W-1:0] solo_count_next;

  function automatic logic [mmsr_pkg::SLOT_W-1:0] slot_of(input logic [mmsr_pkg::ID_W-1:0] id);
    logic [mmsr_pkg::ID_W-1:0] s;
    s = id - mmsr_pkg::ID_W'(1);
    return s[mmsr_pkg::SLOT_W-1:0];
  endfunction

  function automatic logic id_valid(input logic [mmsr_pkg::ID_W-1:0] id);
    return (id != '0) && (id <= mmsr_pkg::ID_W'(mmsr_pkg::MAX_TRACKS));
  endfunction

  function automatic logic aud_of(input logic grp, input logic mut, input logic sol,
                                  input logic manc, input logic sanc, input logic no_solo);
    return !(grp || mut || manc) && (no_solo || sol || sanc);
  endfunction

  mmsr_ram #(
    .WIDTH(mmsr_pkg::ENTRY_W),
    .DEPTH(mmsr_pkg::MAX_TRACKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_of(cur_id)),
    .wdata(entry_wr),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // An entry that was never written since reset reads as absent.
  assign entry_rd = vld[rd_slot] ? mmsr_pkg::entry_t'(ram_rdata) : '0;

  assign id_ok    = id_valid(cur_id);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    entry_wr = '0;
    if (cur_present) begin
      entry_wr.present = 1'b1;
      entry_wr.parent  = cur_parent;
      entry_wr.muted   = cur_muted;
      entry_wr.soloed  = cur_soloed;
      entry_wr.group   = cur_group;
    end
  end

  assign track_count_next = track_count - mmsr_pkg::CNT_W'(entry_rd.present)
                          + mmsr_pkg::CNT_W'(cur_present);
  assign solo_count_next  = solo_count - mmsr_pkg::CNT_W'(entry_rd.present & entry_rd.soloed)
                          + mmsr_pkg::CNT_W'(cur_present & cur_soloed);

  // The next ancestor is always the parent field of the entry just read.
  assign cand_steps = (state == S_WALK) ? steps + mmsr_pkg::CNT_W'(1) : '0;
  assign cand_ok    = (entry_rd.parent != '0) && (cand_steps < track_count)
                    && id_valid(entry_rd.parent);
  assign walk_stop  = !entry_rd.present || (entry_rd.parent == walk_pid);
  assign mute_n     = mute_anc | entry_rd.muted;
  assign solo_n     = solo_anc | entry_rd.soloed;

  assign ram_we = (state == S_LOOKUP) && !cur_mode && id_ok;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = slot_of(entry_rd.parent);
    case (state)
      S_IDLE: begin
        ram_re    = req.valid;
        ram_raddr = slot_of(req.track_id);
      end
      S_LOOKUP: ram_re = cur_mode && id_ok && entry_rd.present && cand_ok;
      S_WALK:   ram_re = !walk_stop && cand_ok;
      default:  ram_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_slot <= ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vld         <= '0;
      track_count <= '0;
      solo_count  <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      // The done state reloads the result register itself when it is free.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_mode    <= req.mode;
            cur_id      <= req.track_id;
            cur_present <= req.present;
            cur_parent  <= req.parent_id;
            cur_muted   <= req.muted_flag;
            cur_soloed  <= req.soloed_flag;
            cur_group   <= req.is_group;
            state       <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (!cur_mode) begin
            res_aud   <= 1'b0;
            res_known <= id_ok && cur_present;
            state     <= S_DONE;
            if (id_ok) begin
              track_count         <= track_count_next;
              solo_count          <= solo_count_next;
              vld[slot_of(cur_id)] <= 1'b1;
            end
          end else if (id_ok && entry_rd.present) begin
            res_known  <= 1'b1;
            own_muted  <= entry_rd.muted;
            own_soloed <= entry_rd.soloed;
            own_group  <= entry_rd.group;
            mute_anc   <= 1'b0;
            solo_anc   <= 1'b0;
            walk_pid   <= entry_rd.parent;
            steps      <= '0;
            if (cand_ok) begin
              state <= S_WALK;
            end else begin
              res_aud <= aud_of(entry_rd.group, entry_rd.muted, entry_rd.soloed,
                                1'b0, 1'b0, solo_count == '0);
              state   <= S_DONE;
            end
          end else begin
            res_aud   <= 1'b0;
            res_known <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            // A missing or self-parented ancestor ends the walk without counting.
            res_aud <= aud_of(own_group, own_muted, own_soloed, mute_anc, solo_anc,
                              solo_count == '0);
            state   <= S_DONE;
          end else begin
            mute_anc <= mute_n;
            solo_anc <= solo_n;
            walk_pid <= entry_rd.parent;
            steps    <= cand_steps;
            if (!cand_ok) begin
              res_aud <= aud_of(own_group, own_muted, own_soloed, mute_n, solo_n,
                                solo_count == '0);
              state   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid    <= 1'b1;
            rsp.audible  <= res_aud;
            rsp.known    <= res_known;
            rsp.any_solo <= (solo_count != '0);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_solo_le_tracks: assert property (@(posedge clk) disable iff (rst)
    solo_count <= track_count)
    else $error("solo count exceeds track count");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps < track_count))
    else $error("walk ran past the present-track count");

  a_walk_pid_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_pid != '0) && (rd_slot == slot_of(walk_pid)))
    else $error("walk reads a slot other than the current ancestor");

  a_audible_known: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (!rsp.audible || rsp.known))
    else $error("audible result for an unknown track");

  a_write_from_lookup: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (state == S_DONE) && !res_aud)
    else $error("table write outside a write word");

endmodule

`default_nettype wire
